// ===== src/pfa_pkg.sv =====
package pfa_pkg;

  // Table geometry and field widths.
  localparam int unsigned PARTS    = 16;
  localparam int unsigned IDX_W    = $clog2(PARTS);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Request type codes carried in req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic REG_FIT_MODE   = 1'b0;
  localparam logic REG_PART_COUNT = 1'b1;

  // Placement policies. The unused code behaves as first fit.
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Configuration handed from the register block to the allocator core.
  typedef struct packed {
    logic [MODE_W-1:0] fit_mode;
    logic [CNT_W-1:0]  part_count;
  } cfg_t;

endpackage

// ===== src/partition_fit_allocator_top.sv =====
// Partition fit allocator. A load transfer is written into the table at its acceptance edge.
// A request stalls the input while the scan compares each used partition in turn, reading
// the table through its registered port, and then writes the chosen entry back. No new
// transfer is taken until that write-back, which also registers the result. A count of zero
// skips the scan, and a full result register holds the write-back.
// Asynchronous active-low reset clears the control state and selects first fit, count 16.
module partition_fit_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port. pready is tied high, so every access ends in its
  // access cycle.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfa_pkg::APB_AW-1:0]    paddr,
  input  logic [pfa_pkg::APB_DW-1:0]    pwdata,
  output logic [pfa_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // Input item channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [pfa_pkg::IDX_W-1:0]     part_index_i,
  input  logic [pfa_pkg::SIZE_W-1:0]    size_kb_i,
  input  logic                          final_request_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          placed_o,
  output logic [pfa_pkg::IDX_W-1:0]     slot_o,
  output logic [pfa_pkg::SIZE_W-1:0]    free_before_o,
  output logic                          batch_end_o
);

  logic [pfa_pkg::MODE_W-1:0] fit_mode_q;
  logic [pfa_pkg::CNT_W-1:0]  part_count_q;
  logic                       reg_sel;
  logic                       cfg_wr;
  pfa_pkg::cfg_t              cfg;

  // Registers sit at byte addresses 0 and 4, so address bit 2 picks one.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= pfa_pkg::FIT_FIRST;
      part_count_q <= pfa_pkg::CNT_W'(pfa_pkg::PARTS);
    end else if (cfg_wr) begin
      case (reg_sel)
        pfa_pkg::REG_FIT_MODE:   fit_mode_q   <= pwdata[pfa_pkg::MODE_W-1:0];
        pfa_pkg::REG_PART_COUNT: part_count_q <= pwdata[pfa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register, zero extended to the bus width.
  always_comb begin
    case (reg_sel)
      pfa_pkg::REG_FIT_MODE:   prdata = pfa_pkg::APB_DW'(fit_mode_q);
      pfa_pkg::REG_PART_COUNT: prdata = pfa_pkg::APB_DW'(part_count_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.fit_mode   = fit_mode_q;
  assign cfg.part_count = part_count_q;

  // The core holds the table, the scan sequencer and the result register, so
  // a finished result can wait on the output while loads keep flowing in.
  pfa_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .part_index_i    (part_index_i),
    .size_kb_i       (size_kb_i),
    .final_request_i (final_request_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .placed_o        (placed_o),
    .slot_o          (slot_o),
    .free_before_o   (free_before_o),
    .batch_end_o     (batch_end_o)
  );

endmodule

// ===== src/pfa_core.sv =====
module pfa_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfa_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [pfa_pkg::IDX_W-1:0]     part_index_i,
  input  logic [pfa_pkg::SIZE_W-1:0]    size_kb_i,
  input  logic                          final_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          placed_o,
  output logic [pfa_pkg::IDX_W-1:0]     slot_o,
  output logic [pfa_pkg::SIZE_W-1:0]    free_before_o,
  output logic                          batch_end_o
);

  pfa_pkg::state_e state_q, state_d;

  logic [pfa_pkg::SIZE_W-1:0] mem_q [pfa_pkg::PARTS];
  logic [pfa_pkg::SIZE_W-1:0] rdata_q;

  logic [pfa_pkg::SIZE_W-1:0] req_size_q;
  logic                       req_fin_q;
  logic [pfa_pkg::MODE_W-1:0] mode_q;
  logic [pfa_pkg::CNT_W-1:0]  n_q;
  logic [pfa_pkg::CNT_W-1:0]  n_clamp;
  logic [pfa_pkg::CNT_W-1:0]  n_last;

  logic [pfa_pkg::CNT_W-1:0]  scan_q;
  logic                       cmp_vld_q;
  logic [pfa_pkg::IDX_W-1:0]  cmp_idx_q;

  logic                       have_q;
  logic [pfa_pkg::SIZE_W-1:0] cand_val_q;
  logic [pfa_pkg::IDX_W-1:0]  cand_idx_q;

  logic                       out_vld_q;
  logic                       placed_q;
  logic [pfa_pkg::IDX_W-1:0]  slot_q;
  logic [pfa_pkg::SIZE_W-1:0] free_q;
  logic                       batch_q;

  logic accept, is_load, is_req, out_free, issue, last_cmp;
  logic fits, take, place, finish;
  logic                       mem_we;
  logic [pfa_pkg::IDX_W-1:0]  mem_waddr;
  logic [pfa_pkg::SIZE_W-1:0] mem_wdata;

  assign n_clamp = (cfg_i.part_count > pfa_pkg::CNT_W'(pfa_pkg::PARTS)) ?
                   pfa_pkg::CNT_W'(pfa_pkg::PARTS) : cfg_i.part_count;
  assign n_last  = n_q - pfa_pkg::CNT_W'(1);

  assign accept   = in_valid_i && !in_stall_o;
  assign is_load  = accept && (req_type_i == pfa_pkg::REQ_LOAD);
  assign is_req   = accept && (req_type_i == pfa_pkg::REQ_ALLOC);
  assign out_free = !out_vld_q || !out_stall_i;
  assign issue    = (state_q == pfa_pkg::ST_SCAN) && (scan_q < n_q);
  assign last_cmp = cmp_vld_q && (cmp_idx_q == n_last[pfa_pkg::IDX_W-1:0]);

  // Shared compare unit: one table entry per cycle against the current candidate
  // and, for first and best fit, against the request.
  assign fits = rdata_q >= req_size_q;
  always_comb begin
    case (mode_q)
      pfa_pkg::FIT_BEST:  take = fits && (!have_q || (rdata_q < cand_val_q));
      pfa_pkg::FIT_WORST: take = !have_q || (rdata_q > cand_val_q);
      default:            take = fits && !have_q;
    endcase
  end

  // Worst fit keeps the largest entry and only uses it if it fits.
  assign place = have_q && ((mode_q != pfa_pkg::FIT_WORST) || (cand_val_q >= req_size_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (is_req) begin
          state_d = (n_clamp == '0) ? pfa_pkg::ST_UPDATE : pfa_pkg::ST_SCAN;
        end
      end
      pfa_pkg::ST_SCAN: begin
        if (last_cmp) begin
          state_d = pfa_pkg::ST_UPDATE;
        end
      end
      pfa_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = pfa_pkg::ST_IDLE;
        end
      end
      default: state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    finish     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cand_idx_q;
    mem_wdata  = cand_val_q - req_size_q;
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_we     = is_load;
        mem_waddr  = part_index_i;
        mem_wdata  = size_kb_i;
      end
      pfa_pkg::ST_UPDATE: begin
        finish = out_free;
        mem_we = out_free && place;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfa_pkg::ST_IDLE;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (is_req) begin
        scan_q <= '0;
        have_q <= 1'b0;
      end else begin
        if (issue) begin
          scan_q <= scan_q + pfa_pkg::CNT_W'(1);
        end
        if (cmp_vld_q && take) begin
          have_q <= 1'b1;
        end
      end
      cmp_vld_q <= issue;
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_req) begin
      req_size_q <= size_kb_i;
      req_fin_q  <= final_request_i;
      mode_q     <= cfg_i.fit_mode;
      n_q        <= n_clamp;
    end
    cmp_idx_q <= scan_q[pfa_pkg::IDX_W-1:0];
    if (cmp_vld_q && take) begin
      cand_val_q <= rdata_q;
      cand_idx_q <= cmp_idx_q;
    end
    if (finish) begin
      placed_q <= place;
      slot_q   <= place ? cand_idx_q : '0;
      free_q   <= place ? cand_val_q : '0;
      batch_q  <= req_fin_q;
    end
  end

  // Free size table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[scan_q[pfa_pkg::IDX_W-1:0]];
  end

  assign out_valid_o   = out_vld_q;
  assign placed_o      = placed_q;
  assign slot_o        = slot_q;
  assign free_before_o = free_q;
  assign batch_end_o   = batch_q;

  a_req_holds_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_req |=> in_stall_o)
    else $error("block accepted a transfer right after a request");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> ({1'b0, cmp_idx_q} < n_q))
    else $error("scan compared an entry beyond the partition count");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfa_pkg::ST_SCAN) |-> (scan_q <= n_q))
    else $error("scan address ran past the partition count");

  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !placed_q) |-> ((slot_q == '0) && (free_q == '0)))
    else $error("waiting result carries a slot or size");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pfa_pkg::ST_UPDATE) && out_vld_q && out_stall_i) |=>
      (state_q == pfa_pkg::ST_UPDATE))
    else $error("result finished while the output register was still full");

endmodule
